/* rtl/lbid_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbid_pkg: shared constants and types of the led blink id decoder
// widths, register indexes and the lookup table layout
// ----------------------------------------------------------------------------
package lbid_pkg;

   localparam int MAX_FRAMES_DEFAULT = 256;
   localparam int ID_ENTRIES_DEFAULT = 16;

   localparam int TABLE_ENTRIES = 16;
   localparam int ID_W          = 4;
   localparam int COUNT_W       = 5;
   localparam int MEAS_W        = 8;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_ADDR_W    = 6;
   localparam int REG_INDEX_W   = 3;

   localparam logic [REG_INDEX_W-1:0] REG_PERIOD_LOW  = 3'd0;
   localparam logic [REG_INDEX_W-1:0] REG_PERIOD_HIGH = 3'd1;
   localparam logic [REG_INDEX_W-1:0] REG_ON_LOW      = 3'd2;
   localparam logic [REG_INDEX_W-1:0] REG_ON_HIGH     = 3'd3;
   localparam logic [REG_INDEX_W-1:0] REG_ID_COUNT    = 3'd4;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] period_high;
      logic [CSR_DATA_W-1:0] period_low;
      logic [CSR_DATA_W-1:0] on_high;
      logic [CSR_DATA_W-1:0] on_low;
      logic [COUNT_W-1:0]    id_count;
   } id_table_type;

endpackage
`default_nettype wire

/* rtl/lbid_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbid_tracker: edge tracker of the presence bit stream
// keeps the positions of the first three transitions and, on the last item,
// holds measured period and on-time in a snapshot register for the matcher
// ----------------------------------------------------------------------------
module lbid_tracker #(
   parameter int MAX_FRAMES = lbid_pkg::MAX_FRAMES_DEFAULT,
   parameter int FRAME_W    = $clog2(MAX_FRAMES)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic               led_on,
   input  wire logic               last,
   input  wire logic               advance,
   output logic                    meas_valid,
   output logic                    meas_enough,
   output logic [FRAME_W-1:0]      meas_period,
   output logic [FRAME_W-1:0]      meas_on
);

   localparam logic [FRAME_W-1:0] FRAME_LAST = FRAME_W'(MAX_FRAMES - 1);

   logic               prev_ff, prev_in;
   logic               have_prev_ff, have_prev_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [1:0]         count_ff, count_in;
   logic               rising_ff, rising_in;
   logic [FRAME_W-1:0] pos_ff [3];
   logic [FRAME_W-1:0] pos_in [3];
   logic               meas_valid_ff, meas_valid_in;
   logic               enough_ff;
   logic [FRAME_W-1:0] period_ff;
   logic [FRAME_W-1:0] on_ff;
   logic               edge_seen;
   logic [FRAME_W-1:0] edge_pos;
   logic               rising_upd;
   logic [1:0]         count_upd;

   always_comb begin
      edge_seen  = have_prev_ff && (led_on != prev_ff) && (count_ff != 2'd3);
      edge_pos   = frame_ff - FRAME_W'(1);
      count_upd  = edge_seen ? count_ff + 2'd1 : count_ff;
      rising_upd = (edge_seen && (count_ff == 2'd0)) ? led_on : rising_ff;
      for (int k = 0; k < 3; k++) begin
         pos_in[k] = (edge_seen && (count_ff == 2'(k))) ? edge_pos : pos_ff[k];
      end

      prev_in       = prev_ff;
      have_prev_in  = have_prev_ff;
      frame_in      = frame_ff;
      count_in      = count_ff;
      rising_in     = rising_ff;
      meas_valid_in = meas_valid_ff;
      if (advance) begin
         meas_valid_in = 1'b0;
      end
      if (accept) begin
         if (last) begin
            // sequence ends: clear the tracking state
            prev_in       = 1'b0;
            have_prev_in  = 1'b0;
            frame_in      = '0;
            count_in      = 2'd0;
            rising_in     = 1'b0;
            meas_valid_in = 1'b1;
         end else begin
            prev_in      = led_on;
            have_prev_in = 1'b1;
            frame_in     = (frame_ff != FRAME_LAST) ? frame_ff + FRAME_W'(1) : frame_ff;
            count_in     = count_upd;
            rising_in    = rising_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff       <= 1'b0;
         have_prev_ff  <= 1'b0;
         frame_ff      <= '0;
         count_ff      <= 2'd0;
         rising_ff     <= 1'b0;
         meas_valid_ff <= 1'b0;
      end else begin
         prev_ff       <= prev_in;
         have_prev_ff  <= have_prev_in;
         frame_ff      <= frame_in;
         count_ff      <= count_in;
         rising_ff     <= rising_in;
         meas_valid_ff <= meas_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < 3; k++) begin
            pos_ff[k] <= pos_in[k];
         end
      end
      if (accept && last) begin
         enough_ff <= (count_upd == 2'd3);
         period_ff <= pos_in[2] - pos_in[0];
         on_ff     <= rising_upd ? pos_in[1] - pos_in[0] : pos_in[2] - pos_in[1];
      end
   end

   assign meas_valid  = meas_valid_ff;
   assign meas_enough = enough_ff;
   assign meas_period = period_ff;
   assign meas_on     = on_ff;

endmodule
`default_nettype wire

/* rtl/lbid_matcher.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbid_matcher: id table compare
// compares period and on-time against the entries below the id count and
// picks the lowest matching id from 1 upward, then saturates the measurements
// ----------------------------------------------------------------------------
module lbid_matcher #(
   parameter int ID_ENTRIES = lbid_pkg::ID_ENTRIES_DEFAULT,
   parameter int FRAME_W    = $clog2(lbid_pkg::MAX_FRAMES_DEFAULT)
) (
   input  wire lbid_pkg::id_table_type         table_cfg,
   input  wire logic                           enough,
   input  wire logic [FRAME_W-1:0]             period,
   input  wire logic [FRAME_W-1:0]             on_time,
   output logic [lbid_pkg::ID_W-1:0]           object_id,
   output logic                                identified,
   output logic [lbid_pkg::MEAS_W-1:0]         period_frames,
   output logic [lbid_pkg::MEAS_W-1:0]         on_frames
);

   localparam int CW = ((FRAME_W > lbid_pkg::MEAS_W) ? FRAME_W : lbid_pkg::MEAS_W) + 1;
   localparam logic [CW-1:0] MEAS_MAX = CW'((1 << lbid_pkg::MEAS_W) - 1);

   logic [2*lbid_pkg::CSR_DATA_W-1:0] period_bytes;
   logic [2*lbid_pkg::CSR_DATA_W-1:0] on_bytes;
   logic [CW-1:0]                     p_ext, t_ext, mp, mt;
   logic [ID_ENTRIES-1:0]             hit;
   logic                              found;
   logic [lbid_pkg::ID_W-1:0]         vid;

   always_comb begin
      period_bytes = {table_cfg.period_high, table_cfg.period_low};
      on_bytes     = {table_cfg.on_high, table_cfg.on_low};
      mp           = CW'(period);
      mt           = CW'(on_time);
      hit          = '0;
      for (int id = 1; id < ID_ENTRIES; id++) begin
         p_ext   = CW'(period_bytes[id*lbid_pkg::MEAS_W +: lbid_pkg::MEAS_W]);
         t_ext   = CW'(on_bytes[id*lbid_pkg::MEAS_W +: lbid_pkg::MEAS_W]);
         hit[id] = (lbid_pkg::COUNT_W'(id) < table_cfg.id_count)
                && ((mp == p_ext) || (mp == p_ext + CW'(1)) || (mp + CW'(1) == p_ext))
                && ((mt == t_ext) || (mt == t_ext + CW'(1)) || (mt + CW'(1) == t_ext));
      end
      // lowest id wins
      found = 1'b0;
      vid   = '0;
      for (int id = 1; id < ID_ENTRIES; id++) begin
         if (!found && hit[id]) begin
            found = 1'b1;
            vid   = lbid_pkg::ID_W'(id);
         end
      end

      if (enough) begin
         object_id     = vid;
         identified    = found;
         period_frames = (mp > MEAS_MAX) ? lbid_pkg::MEAS_W'(MEAS_MAX)
                                         : lbid_pkg::MEAS_W'(mp);
         on_frames     = (mt > MEAS_MAX) ? lbid_pkg::MEAS_W'(MEAS_MAX)
                                         : lbid_pkg::MEAS_W'(mt);
      end else begin
         object_id     = '0;
         identified    = 1'b0;
         period_frames = '0;
         on_frames     = '0;
      end
   end

endmodule
`default_nettype wire

/* rtl/led_blink_id_decoder_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_blink_id_decoder_top: led blink id decoder
// identifies a tracked object from its blink period and on-time
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_led_on, req_last
//   rsp     | out       | rsp_valid/rsp_stall | rsp_object_id, rsp_identified,
//           |           |                     | rsp_period_frames, rsp_on_frames
//   csr     | in/out    | apb, pready high    | 64 bit registers at 8*index
//
// one item per cycle while req_stall is low; a result passes from its last item
// through the snapshot register and the table compare into the output register
// reset is synchronous and clears the tracking state and the configuration registers
// req_stall rises only when the snapshot and output registers are both full
// and rsp_stall holds the output
// ----------------------------------------------------------------------------
module led_blink_id_decoder_top #(
   parameter int MAX_FRAMES = lbid_pkg::MAX_FRAMES_DEFAULT,
   parameter int ID_ENTRIES = lbid_pkg::ID_ENTRIES_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_led_on,
   input  wire logic                               req_last,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [lbid_pkg::ID_W-1:0]               rsp_object_id,
   output logic                                    rsp_identified,
   output logic [lbid_pkg::MEAS_W-1:0]             rsp_period_frames,
   output logic [lbid_pkg::MEAS_W-1:0]             rsp_on_frames,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [lbid_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [lbid_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [lbid_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                    csr_pready
);

   localparam int FRAME_W = $clog2(MAX_FRAMES);

   lbid_pkg::id_table_type              table_ff, table_in;
   logic [lbid_pkg::REG_INDEX_W-1:0]    reg_index;
   logic                                csr_write;

   logic                                accept;
   logic                                out_free;
   logic                                advance;
   logic                                meas_valid;
   logic                                meas_enough;
   logic [FRAME_W-1:0]                  meas_period;
   logic [FRAME_W-1:0]                  meas_on;

   logic [lbid_pkg::ID_W-1:0]           match_id;
   logic                                match_found;
   logic [lbid_pkg::MEAS_W-1:0]         match_period;
   logic [lbid_pkg::MEAS_W-1:0]         match_on;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [lbid_pkg::ID_W-1:0]           object_id_ff;
   logic                                identified_ff;
   logic [lbid_pkg::MEAS_W-1:0]         period_ff;
   logic [lbid_pkg::MEAS_W-1:0]         on_ff;

   // configuration registers
   assign reg_index  = csr_paddr[lbid_pkg::CSR_ADDR_W-1 -: lbid_pkg::REG_INDEX_W];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      table_in = table_ff;
      if (csr_write) begin
         case (reg_index)
            lbid_pkg::REG_PERIOD_LOW:  table_in.period_low  = csr_pwdata;
            lbid_pkg::REG_PERIOD_HIGH: table_in.period_high = csr_pwdata;
            lbid_pkg::REG_ON_LOW:      table_in.on_low      = csr_pwdata;
            lbid_pkg::REG_ON_HIGH:     table_in.on_high     = csr_pwdata;
            lbid_pkg::REG_ID_COUNT:    table_in.id_count    =
               csr_pwdata[lbid_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         lbid_pkg::REG_PERIOD_LOW:  csr_prdata = table_ff.period_low;
         lbid_pkg::REG_PERIOD_HIGH: csr_prdata = table_ff.period_high;
         lbid_pkg::REG_ON_LOW:      csr_prdata = table_ff.on_low;
         lbid_pkg::REG_ON_HIGH:     csr_prdata = table_ff.on_high;
         lbid_pkg::REG_ID_COUNT:    csr_prdata = lbid_pkg::CSR_DATA_W'(table_ff.id_count);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_ff <= '0;
      end else begin
         table_ff <= table_in;
      end
   end

   // flow control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = meas_valid && out_free;
   assign req_stall = meas_valid && !out_free;
   assign accept    = req_valid && !req_stall;

   lbid_tracker #(
      .MAX_FRAMES (MAX_FRAMES),
      .FRAME_W    (FRAME_W)
   ) u_tracker (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .led_on      (req_led_on),
      .last        (req_last),
      .advance     (advance),
      .meas_valid  (meas_valid),
      .meas_enough (meas_enough),
      .meas_period (meas_period),
      .meas_on     (meas_on)
   );

   lbid_matcher #(
      .ID_ENTRIES (ID_ENTRIES),
      .FRAME_W    (FRAME_W)
   ) u_matcher (
      .table_cfg     (table_ff),
      .enough        (meas_enough),
      .period        (meas_period),
      .on_time       (meas_on),
      .object_id     (match_id),
      .identified    (match_found),
      .period_frames (match_period),
      .on_frames     (match_on)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         object_id_ff  <= match_id;
         identified_ff <= match_found;
         period_ff     <= match_period;
         on_ff         <= match_on;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_object_id     = object_id_ff;
   assign rsp_identified    = identified_ff;
   assign rsp_period_frames = period_ff;
   assign rsp_on_frames     = on_ff;

   // checks
   a_id_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_identified == (rsp_object_id != '0)))
      else $error("identified flag disagrees with object id");

   a_last_snap : assert property (@(posedge clock) disable iff (reset)
      (accept && req_last) |=> meas_valid)
      else $error("last item left no snapshot");

   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(meas_valid))
      else $error("result appeared without a snapshot");

endmodule
`default_nettype wire

/* bench/led_blink_id_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_blink_id_check: result checker for the led blink id decoder
// follows the register port and every accepted item, works out the decode
// expected for each sequence and compares it field by field with the results
// ----------------------------------------------------------------------------
module led_blink_id_check #(
   parameter int MAX_FRAMES = lbid_pkg::MAX_FRAMES_DEFAULT,
   parameter int ID_ENTRIES = lbid_pkg::ID_ENTRIES_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_stall,
   input  wire logic                            req_led_on,
   input  wire logic                            req_last,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   input  wire logic [lbid_pkg::ID_W-1:0]       rsp_object_id,
   input  wire logic                            rsp_identified,
   input  wire logic [lbid_pkg::MEAS_W-1:0]     rsp_period_frames,
   input  wire logic [lbid_pkg::MEAS_W-1:0]     rsp_on_frames,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [lbid_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [lbid_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic [lbid_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  wire logic                            csr_pready,
   output int                                   fail_count,
   output int                                   pending,
   output int                                   decode_count,
   output int                                   match_count
);

   typedef struct packed {
      logic [lbid_pkg::ID_W-1:0]   object_id;
      logic                        identified;
      logic [lbid_pkg::MEAS_W-1:0] period_frames;
      logic [lbid_pkg::MEAS_W-1:0] on_frames;
   } decode_type;

   logic [lbid_pkg::CSR_DATA_W-1:0] period_low, period_high, on_low, on_high;
   logic [lbid_pkg::COUNT_W-1:0]    ids_in_use;

   logic       prev_led, have_prev, first_rising;
   int         frame_no, edges_seen;
   int         edge_at [3];
   decode_type expected_q [$];
   int         errors, decodes, hit_total;

   function automatic int table_byte(input logic [63:0] lo, input logic [63:0] hi,
                                     input int id);
      logic [63:0] word;
      word = (id < 8) ? lo : hi;
      return int'(word[(id % 8) * 8 +: 8]);
   endfunction

   function automatic bit within_one(input int measured, input int wanted);
      return (measured - wanted >= -1) && (measured - wanted <= 1);
   endfunction

   function automatic void clear_track();
      prev_led     = 1'b0;
      have_prev    = 1'b0;
      first_rising = 1'b0;
      frame_no     = 0;
      edges_seen   = 0;
      edge_at      = '{0, 0, 0};
   endfunction

   function automatic decode_type decode_sequence();
      decode_type d;
      int         span, high_run, limit, id;
      d = '0;
      if (edges_seen == 3) begin
         span     = edge_at[2] - edge_at[0];
         high_run = first_rising ? edge_at[1] - edge_at[0] : edge_at[2] - edge_at[1];
         limit    = (ids_in_use > ID_ENTRIES) ? ID_ENTRIES : int'(ids_in_use);
         // entry 0 is never a candidate, lowest matching id wins
         for (id = 1; id < limit && !d.identified; id++) begin
            if (within_one(high_run, table_byte(on_low, on_high, id)) &&
                within_one(span, table_byte(period_low, period_high, id))) begin
               d.object_id  = id[lbid_pkg::ID_W-1:0];
               d.identified = 1'b1;
            end
         end
         d.period_frames = (span > 255) ? 8'hFF : span[7:0];
         d.on_frames     = (high_run > 255) ? 8'hFF : high_run[7:0];
      end
      return d;
   endfunction

   function automatic void take_frame(input logic led, input logic fin);
      decode_type d;
      if (have_prev && led != prev_led && edges_seen < 3) begin
         if (edges_seen == 0) first_rising = led;
         edge_at[edges_seen] = frame_no - 1;
         edges_seen++;
      end
      prev_led  = led;
      have_prev = 1'b1;
      if (frame_no < MAX_FRAMES - 1) frame_no++;
      if (fin) begin
         d          = decode_sequence();
         expected_q = {expected_q, d};
         clear_track();
      end
   endfunction

   always @(posedge clock) begin
      decode_type  want;
      logic [63:0] reg_now;
      if (reset) begin
         period_low  = '0;
         period_high = '0;
         on_low      = '0;
         on_high     = '0;
         ids_in_use  = '0;
         clear_track();
         expected_q.delete();
         errors    = 0;
         decodes   = 0;
         hit_total = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            case (csr_paddr[lbid_pkg::CSR_ADDR_W-1:3])
               lbid_pkg::REG_PERIOD_LOW:  reg_now = period_low;
               lbid_pkg::REG_PERIOD_HIGH: reg_now = period_high;
               lbid_pkg::REG_ON_LOW:      reg_now = on_low;
               lbid_pkg::REG_ON_HIGH:     reg_now = on_high;
               lbid_pkg::REG_ID_COUNT:    reg_now = 64'(ids_in_use);
               default:                   reg_now = '0;
            endcase
            if (csr_pwrite) begin
               case (csr_paddr[lbid_pkg::CSR_ADDR_W-1:3])
                  lbid_pkg::REG_PERIOD_LOW:  period_low  = csr_pwdata;
                  lbid_pkg::REG_PERIOD_HIGH: period_high = csr_pwdata;
                  lbid_pkg::REG_ON_LOW:      on_low      = csr_pwdata;
                  lbid_pkg::REG_ON_HIGH:     on_high     = csr_pwdata;
                  lbid_pkg::REG_ID_COUNT:    ids_in_use  = csr_pwdata[lbid_pkg::COUNT_W-1:0];
                  default: ;
               endcase
            end else if (csr_prdata !== reg_now) begin
               $error("csr read at 0x%0h: expected %h, got %h", csr_paddr, reg_now, csr_prdata);
               errors++;
            end
         end
         if (req_valid && !req_stall) take_frame(req_led_on, req_last);
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("result item arrived with nothing expected");
               errors++;
            end else begin
               want = expected_q.pop_front();
               decodes++;
               if (want.identified) hit_total++;
               if (rsp_object_id !== want.object_id) begin
                  $error("object_id: expected %0d, got %0d", want.object_id, rsp_object_id);
                  errors++;
               end
               if (rsp_identified !== want.identified) begin
                  $error("identified: expected %0d, got %0d", want.identified, rsp_identified);
                  errors++;
               end
               if (rsp_period_frames !== want.period_frames) begin
                  $error("period_frames: expected %0d, got %0d",
                         want.period_frames, rsp_period_frames);
                  errors++;
               end
               if (rsp_on_frames !== want.on_frames) begin
                  $error("on_frames: expected %0d, got %0d", want.on_frames, rsp_on_frames);
                  errors++;
               end
            end
         end
      end
      fail_count   <= errors;
      pending      <= expected_q.size();
      decode_count <= decodes;
      match_count  <= hit_total;
   end

endmodule

/* bench/led_blink_id_decoder_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_blink_id_decoder_top_test: testbench of the led blink id decoder
// loads several id tables over the register port and sends directed
// sequences and random sequences, many shaped around the table entries, with
// random idling on both channels; the checker compares every result
// ----------------------------------------------------------------------------
module led_blink_id_decoder_top_test;

   typedef enum int { TABLE_SMALL, TABLE_SATURATED, TABLE_MIXED } table_kind_type;

   logic                                clock, reset;
   logic                                req_valid, req_stall, req_led_on, req_last;
   logic                                rsp_valid, rsp_stall, rsp_identified;
   logic [lbid_pkg::ID_W-1:0]           rsp_object_id;
   logic [lbid_pkg::MEAS_W-1:0]         rsp_period_frames, rsp_on_frames;
   logic                                csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [lbid_pkg::CSR_ADDR_W-1:0]     csr_paddr;
   logic [lbid_pkg::CSR_DATA_W-1:0]     csr_pwdata, csr_prdata;

   int fail_count, pending, decode_count, match_count;

   logic [lbid_pkg::MEAS_W-1:0] tab_period [lbid_pkg::TABLE_ENTRIES];
   logic [lbid_pkg::MEAS_W-1:0] tab_on     [lbid_pkg::TABLE_ENTRIES];
   logic                        frame_q [$];
   int                          frames_sent;
   int                          idle_odds;
   int                          stall_left;

   led_blink_id_decoder_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_led_on        (req_led_on),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_object_id     (rsp_object_id),
      .rsp_identified    (rsp_identified),
      .rsp_period_frames (rsp_period_frames),
      .rsp_on_frames     (rsp_on_frames),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   led_blink_id_check u_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_led_on        (req_led_on),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_object_id     (rsp_object_id),
      .rsp_identified    (rsp_identified),
      .rsp_period_frames (rsp_period_frames),
      .rsp_on_frames     (rsp_on_frames),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready),
      .fail_count        (fail_count),
      .pending           (pending),
      .decode_count      (decode_count),
      .match_count       (match_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // result side holds off in random bursts
   always @(posedge clock) begin
      if (reset || idle_odds == 0) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(1, idle_odds) == 1) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   task automatic csr_access(input logic wr, input logic [lbid_pkg::REG_INDEX_W-1:0] index,
                             input logic [lbid_pkg::CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic fill_table(input table_kind_type kind);
      int span;
      for (int id = 0; id < lbid_pkg::TABLE_ENTRIES; id++) begin
         span = $urandom_range(2, 16);
         if (kind == TABLE_SATURATED) begin
            tab_period[id] = 8'hFF;
            tab_on[id]     = 8'hFF;
         end else if (kind == TABLE_MIXED && $urandom_range(0, 1) == 1) begin
            tab_period[id] = $urandom_range(0, 255);
            tab_on[id]     = $urandom_range(0, 255);
         end else begin
            tab_period[id] = span;
            tab_on[id]     = $urandom_range(1, span - 1);
         end
      end
   endtask

   task automatic load_table(input logic [lbid_pkg::COUNT_W-1:0] count);
      logic [lbid_pkg::CSR_DATA_W-1:0]  period_lo, period_hi, on_lo, on_hi;
      logic [lbid_pkg::REG_INDEX_W-1:0] index;
      for (int id = 0; id < 8; id++) begin
         period_lo[id * 8 +: 8] = tab_period[id];
         period_hi[id * 8 +: 8] = tab_period[id + 8];
         on_lo[id * 8 +: 8]     = tab_on[id];
         on_hi[id * 8 +: 8]     = tab_on[id + 8];
      end
      csr_access(1'b1, lbid_pkg::REG_PERIOD_LOW, period_lo);
      csr_access(1'b1, lbid_pkg::REG_PERIOD_HIGH, period_hi);
      csr_access(1'b1, lbid_pkg::REG_ON_LOW, on_lo);
      csr_access(1'b1, lbid_pkg::REG_ON_HIGH, on_hi);
      csr_access(1'b1, lbid_pkg::REG_ID_COUNT, lbid_pkg::CSR_DATA_W'(count));
      for (index = lbid_pkg::REG_PERIOD_LOW; index <= lbid_pkg::REG_ID_COUNT; index++)
         csr_access(1'b0, index, '0);
   endtask

   task automatic send_frame(input logic led, input logic fin);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_led_on <= led;
      req_last   <= fin;
      do @(posedge clock); while (req_stall);
      frames_sent++;
   endtask

   function automatic void add_run(input logic level, input int count);
      repeat (count) frame_q = {frame_q, level};
   endfunction

   task automatic play_frames();
      for (int i = 0; i < frame_q.size(); i++)
         send_frame(frame_q[i], i == frame_q.size() - 1);
      frame_q.delete();
   endtask

   // three transitions giving the wanted period and on-time, then a few stray bits
   task automatic shaped_blink(input int span, input int high_run, input logic rising,
                               input int lead);
      add_run(!rising, lead + 1);
      if (rising) begin
         add_run(1'b1, high_run);
         add_run(1'b0, span - high_run);
      end else begin
         add_run(1'b0, span - high_run);
         add_run(1'b1, high_run);
      end
      add_run(rising, $urandom_range(1, 3));
      repeat ($urandom_range(0, 3)) add_run($urandom_range(0, 1), 1);
      play_frames();
   endtask

   task automatic random_traffic(input int budget);
      int   start, choice, target, span, high_run, count;
      logic level;
      start = frames_sent;
      while (frames_sent - start < budget) begin
         choice = $urandom_range(0, 19);
         level  = $urandom_range(0, 1);
         if (choice < 13) begin
            target   = $urandom_range(1, lbid_pkg::TABLE_ENTRIES - 1);
            span     = tab_period[target] + $urandom_range(0, 4) - 2;
            high_run = tab_on[target] + $urandom_range(0, 4) - 2;
            if (span < 2 || span > 40 || high_run < 1 || high_run >= span) begin
               span     = $urandom_range(2, 16);
               high_run = $urandom_range(1, span - 1);
            end
            shaped_blink(span, high_run, level, $urandom_range(0, 5));
         end else begin
            if (choice < 17) begin
               repeat ($urandom_range(1, 24)) add_run($urandom_range(0, 1), 1);
            end else begin
               // at most two transitions
               count = $urandom_range(0, 2);
               add_run(level, $urandom_range(1, 6));
               if (count > 0) add_run(!level, $urandom_range(1, 6));
               if (count > 1) add_run(level, $urandom_range(1, 6));
            end
            play_frames();
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_led_on  = 1'b0;
      req_last    = 1'b0;
      rsp_stall   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      idle_odds   = 0;
      stall_left  = 0;
      frames_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset table: single frames, one transition, three transitions with no ids
      idle_odds = 4;
      add_run(1'b1, 1);
      play_frames();
      add_run(1'b0, 1);
      play_frames();
      add_run(1'b0, 1);
      add_run(1'b1, 1);
      play_frames();
      shaped_blink(4, 2, 1'b1, 0);
      drain();

      // entry 0 matches too but is skipped, id 1 only at the tolerance edge
      fill_table(TABLE_SMALL);
      tab_period[0] = 8'd5;
      tab_on[0]     = 8'd2;
      tab_period[1] = 8'd7;
      tab_on[1]     = 8'd3;
      tab_period[2] = 8'd5;
      tab_on[2]     = 8'd2;
      load_table(5'd16);
      shaped_blink(5, 2, 1'b1, 0);
      shaped_blink(6, 4, 1'b0, 0);

      // final tracked transition lands after the frame counter has saturated
      add_run(1'b0, 200);
      add_run(1'b1, 40);
      add_run(1'b0, 20);
      add_run(1'b1, 3);
      repeat (6) add_run($urandom_range(0, 1), 1);
      play_frames();
      random_traffic(220);
      drain();

      idle_odds = 3;
      fill_table(TABLE_SATURATED);
      load_table(5'd31);
      random_traffic(120);
      drain();

      idle_odds = 6;
      fill_table(TABLE_SMALL);
      load_table(5'd17);
      random_traffic(220);
      drain();

      idle_odds = 4;
      fill_table(TABLE_MIXED);
      load_table($urandom_range(0, 31));
      random_traffic(220);
      drain();

      idle_odds = 0;
      fill_table(TABLE_SMALL);
      load_table($urandom_range(2, 16));
      random_traffic(220);
      drain();

      $display("sent %0d frames over five id tables", frames_sent);
      $display("checked %0d decoded sequences, %0d of them identified",
               decode_count, match_count);
      if (fail_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/lbid_pkg.sv
rtl/lbid_tracker.sv
rtl/lbid_matcher.sv
rtl/led_blink_id_decoder_top.sv
bench/led_blink_id_check.sv
bench/led_blink_id_decoder_top_test.sv
